[rtl/mjwm_pkg.sv]
// ----------------------------------------------------------------------------
// mjwm_pkg
// Shared types and constants for the mecanum joystick wheel mixer: register
// map, wheel gain, divider sizing and the divider state word.
// ----------------------------------------------------------------------------
`default_nettype none

package mjwm_pkg;

    // register map: index is paddr[2], registers sit at byte offsets 0 and 4
    localparam logic REG_STICK_CENTER = 1'b0;
    localparam logic REG_DEAD_BAND    = 1'b1;

    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;

    localparam logic [7:0] STICK_CENTER_RST = 8'd128;
    localparam logic [6:0] DEAD_BAND_RST    = 7'd10;

    // wheel gain, multiplied by (gear + 1) and divided by 4
    localparam logic [7:0] WHEEL_GAIN = 8'd120;

    // r / 3 for r up to 255: (r * 171) >> 9
    localparam logic [15:0] RECIP3       = 16'd171;
    localparam int unsigned RECIP3_SHIFT = 9;

    // translation gain divider: 16-bit dividend, 8-bit divisor
    localparam int unsigned DIV_W          = 16;
    localparam int unsigned DIVISOR_W      = 8;
    localparam int unsigned DIV_STEPS      = 4;
    localparam int unsigned DIV_STAGES     = DIV_W / DIV_STEPS;

    // partial remainder and dividend/quotient shift word
    typedef struct packed {
        logic [DIVISOR_W-1:0] rem;
        logic [DIV_W-1:0]     work;
    } div_state_t;

endpackage

`default_nettype wire

[rtl/mjwm_div_step.sv]
// ----------------------------------------------------------------------------
// mjwm_div_step
// Several restoring division steps on one divider state word. Quotient bits
// shift into the bottom of the work word as dividend bits leave the top.
// ----------------------------------------------------------------------------
`default_nettype none

module mjwm_div_step (
    input  wire logic [mjwm_pkg::DIVISOR_W-1:0] divisor,
    input  wire mjwm_pkg::div_state_t           din,
    output mjwm_pkg::div_state_t                dout
);

    mjwm_pkg::div_state_t            st;
    logic [mjwm_pkg::DIVISOR_W:0]    trial;
    logic [mjwm_pkg::DIVISOR_W:0]    diff;
    logic                            qbit;

    // one quotient bit per step, compare and subtract
    always_comb
    begin
        st    = din;
        trial = '0;
        diff  = '0;
        qbit  = 1'b0;
        for (int i = 0; i < int'(mjwm_pkg::DIV_STEPS); i++)
        begin
            trial = {st.rem, st.work[mjwm_pkg::DIV_W-1]};
            diff  = trial - {1'b0, divisor};
            if (trial >= {1'b0, divisor})
            begin
                qbit   = 1'b1;
                st.rem = diff[mjwm_pkg::DIVISOR_W-1:0];
            end
            else
            begin
                qbit   = 1'b0;
                st.rem = trial[mjwm_pkg::DIVISOR_W-1:0];
            end
            st.work = {st.work[mjwm_pkg::DIV_W-2:0], qbit};
        end
        dout = st;
    end

endmodule

`default_nettype wire

[rtl/mecanum_joystick_wheel_mixer.sv]
// ----------------------------------------------------------------------------
// mecanum_joystick_wheel_mixer
// Turns one joystick frame into four held mecanum wheel speeds: deadband and
// shift per axis, translation gain by division, rotation / 3, mixing, gear
// scaling and int16 saturation.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                 | word
//  ---------+---------------------------+-------------------------------------
//  in       | in_valid / in_ready       | strafe_raw drive_raw rotate_raw
//           |                           | gear auto_mode
//  out      | out_valid / out_ready     | four wheel speeds, stick_active,
//           |                           | speeds_updated
//  config   | psel penable pwrite pready| stick_center (0x0), dead_band (0x4)
//
//  One word per cycle sustained while the output is not stalled; each word
//  passes stages a, b, the four divider stages c, d, e, f and the output.
//  Each stage has its own valid bit and advances when empty or when the stage
//  after it advances, so bubbles close up under an output stall.
//  Reset clears all valid bits, loads the register reset values and zeroes
//  the held wheel speeds, which live in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mecanum_joystick_wheel_mixer (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,

    input  wire logic                                 in_valid,
    output      logic                                 in_ready,
    input  wire logic [7:0]                           strafe_raw,
    input  wire logic [7:0]                           drive_raw,
    input  wire logic [7:0]                           rotate_raw,
    input  wire logic [1:0]                           gear,
    input  wire logic                                 auto_mode,

    output      logic                                 out_valid,
    input  wire logic                                 out_ready,
    output      logic signed [15:0]                   front_left_speed,
    output      logic signed [15:0]                   rear_left_speed,
    output      logic signed [15:0]                   front_right_speed,
    output      logic signed [15:0]                   rear_right_speed,
    output      logic                                 stick_active,
    output      logic                                 speeds_updated,

    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [mjwm_pkg::PADDR_W-1:0]         paddr,
    input  wire logic [mjwm_pkg::PDATA_W-1:0]         pwdata,
    output      logic [mjwm_pkg::PDATA_W-1:0]         prdata,
    output      logic                                 pready
);

    typedef struct packed {
        logic              active;
        logic signed [8:0] val;
    } axis_t;

    // fields that ride along the divider stages
    typedef struct packed {
        logic signed [8:0] x_val;
        logic signed [8:0] y_val;
        logic signed [7:0] rt;
        logic              act;
        logic [9:0]        gm;
        logic              auto_on;
    } side_t;

    localparam int unsigned NST = mjwm_pkg::DIV_STAGES;

    // ------------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------------
    logic [7:0] stick_center_reg;
    logic [6:0] dead_band_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stick_center_reg <= mjwm_pkg::STICK_CENTER_RST;
            dead_band_reg    <= mjwm_pkg::DEAD_BAND_RST;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[2])
                mjwm_pkg::REG_STICK_CENTER: stick_center_reg <= pwdata[7:0];
                mjwm_pkg::REG_DEAD_BAND:    dead_band_reg    <= pwdata[6:0];
                default:                    stick_center_reg <= stick_center_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            mjwm_pkg::REG_STICK_CENTER: prdata = {24'd0, stick_center_reg};
            mjwm_pkg::REG_DEAD_BAND:    prdata = {25'd0, dead_band_reg};
            default:                    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // stage enables: a stage loads when empty or when its successor loads
    // ------------------------------------------------------------------------
    logic           a_v_reg, b_v_reg, d_v_reg, e_v_reg, f_v_reg, out_valid_reg;
    logic [NST-1:0] c_v_reg;
    logic           en_a, en_b, en_d, en_e, en_f, en_out;
    logic [NST-1:0] en_c;

    always_comb
    begin
        en_out     = !out_valid_reg || out_ready;
        en_f       = !f_v_reg || en_out;
        en_e       = !e_v_reg || en_f;
        en_d       = !d_v_reg || en_e;
        en_c[NST-1] = !c_v_reg[NST-1] || en_d;
        for (int k = int'(NST) - 2; k >= 0; k--)
        begin
            en_c[k] = !c_v_reg[k] || en_c[k+1];
        end
        en_b = !b_v_reg || en_c[0];
        en_a = !a_v_reg || en_b;
    end

    assign in_ready  = en_a;
    assign out_valid = out_valid_reg;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg       <= 1'b0;
            b_v_reg       <= 1'b0;
            c_v_reg       <= '0;
            d_v_reg       <= 1'b0;
            e_v_reg       <= 1'b0;
            f_v_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en_a)
                a_v_reg <= in_valid;
            if (en_b)
                b_v_reg <= a_v_reg;
            if (en_c[0])
                c_v_reg[0] <= b_v_reg;
            for (int k = 1; k < int'(NST); k++)
            begin
                if (en_c[k])
                    c_v_reg[k] <= c_v_reg[k-1];
            end
            if (en_d)
                d_v_reg <= c_v_reg[NST-1];
            if (en_e)
                e_v_reg <= d_v_reg;
            if (en_f)
                f_v_reg <= e_v_reg;
            if (en_out)
                out_valid_reg <= f_v_reg;
        end
    end

    // ------------------------------------------------------------------------
    // stage a: deadband and shift per axis, gear multiplier
    // ------------------------------------------------------------------------
    function automatic axis_t axis_shift(
        input logic [7:0]        raw,
        input logic signed [9:0] lo,
        input logic signed [9:0] hi
    );
        axis_t             res;
        logic signed [9:0] v;
        logic signed [9:0] diff;
        v = $signed({2'b00, raw});
        if (v < lo)
        begin
            diff       = v - lo;
            res.active = 1'b1;
        end
        else if (v < hi)
        begin
            diff       = '0;
            res.active = 1'b0;
        end
        else
        begin
            diff       = v - hi;
            res.active = 1'b1;
        end
        res.val = diff[8:0];
        return res;
    endfunction

    logic signed [9:0] zone_lo;
    logic signed [9:0] zone_hi;
    axis_t             ax_next, ay_next, ar_next;
    logic [9:0]        gm_next;

    axis_t      a_x_reg, a_y_reg, a_r_reg;
    logic [9:0] a_gm_reg;
    logic       a_auto_reg;

    always_comb
    begin
        zone_lo = $signed({2'b00, stick_center_reg}) - $signed({3'b000, dead_band_reg});
        zone_hi = $signed({2'b00, stick_center_reg}) + $signed({3'b000, dead_band_reg});
        ax_next = axis_shift(strafe_raw, zone_lo, zone_hi);
        ay_next = axis_shift(drive_raw, zone_lo, zone_hi);
        ar_next = axis_shift(rotate_raw, zone_lo, zone_hi);
        gm_next = {2'b00, mjwm_pkg::WHEEL_GAIN} * ({8'd0, gear} + 10'd1);
    end

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            a_x_reg    <= ax_next;
            a_y_reg    <= ay_next;
            a_r_reg    <= ar_next;
            a_gm_reg   <= gm_next;
            a_auto_reg <= auto_mode;
        end
    end

    // ------------------------------------------------------------------------
    // stage b: gain products deadband * |v|, rotation / 3
    // ------------------------------------------------------------------------
    logic signed [8:0]    x_neg, y_neg, r_neg;
    logic [7:0]           x_mag, y_mag, r_mag;
    logic [14:0]          px, py;
    logic [15:0]          r_prod;
    logic [7:0]           rt_mag;
    mjwm_pkg::div_state_t bx_next, by_next;
    side_t                bs_next;

    mjwm_pkg::div_state_t b_x_reg, b_y_reg;
    side_t                b_s_reg;

    always_comb
    begin
        x_neg  = -a_x_reg.val;
        y_neg  = -a_y_reg.val;
        r_neg  = -a_r_reg.val;
        x_mag  = a_x_reg.val[8] ? x_neg[7:0] : a_x_reg.val[7:0];
        y_mag  = a_y_reg.val[8] ? y_neg[7:0] : a_y_reg.val[7:0];
        r_mag  = a_r_reg.val[8] ? r_neg[7:0] : a_r_reg.val[7:0];
        px     = 15'(x_mag) * 15'(dead_band_reg);
        py     = 15'(y_mag) * 15'(dead_band_reg);
        r_prod = 16'(r_mag) * mjwm_pkg::RECIP3;
        rt_mag = 8'(r_prod >> mjwm_pkg::RECIP3_SHIFT);

        bx_next.rem  = '0;
        bx_next.work = {1'b0, px};
        by_next.rem  = '0;
        by_next.work = {1'b0, py};

        bs_next.x_val   = a_x_reg.val;
        bs_next.y_val   = a_y_reg.val;
        bs_next.rt      = a_r_reg.val[8] ? -$signed(rt_mag) : $signed(rt_mag);
        bs_next.act     = a_x_reg.active || a_y_reg.active;
        bs_next.gm      = a_gm_reg;
        bs_next.auto_on = a_auto_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en_b)
        begin
            b_x_reg <= bx_next;
            b_y_reg <= by_next;
            b_s_reg <= bs_next;
        end
    end

    // ------------------------------------------------------------------------
    // stages c: pipelined division by stick_center, one lane per translation axis
    // ------------------------------------------------------------------------
    mjwm_pkg::div_state_t c_x_reg [NST];
    mjwm_pkg::div_state_t c_y_reg [NST];
    side_t                c_s_reg [NST];
    mjwm_pkg::div_state_t cx_in   [NST];
    mjwm_pkg::div_state_t cy_in   [NST];
    mjwm_pkg::div_state_t cx_out  [NST];
    mjwm_pkg::div_state_t cy_out  [NST];

    for (genvar k = 0; k < int'(NST); k++)
    begin : g_div
        if (k == 0)
        begin : g_first
            assign cx_in[k] = b_x_reg;
            assign cy_in[k] = b_y_reg;
        end
        else
        begin : g_rest
            assign cx_in[k] = c_x_reg[k-1];
            assign cy_in[k] = c_y_reg[k-1];
        end

        mjwm_div_step u_div_x (
            .divisor (stick_center_reg),
            .din     (cx_in[k]),
            .dout    (cx_out[k])
        );

        mjwm_div_step u_div_y (
            .divisor (stick_center_reg),
            .din     (cy_in[k]),
            .dout    (cy_out[k])
        );

        always_ff @(posedge clk)
        begin
            if (en_c[k])
            begin
                c_x_reg[k] <= cx_out[k];
                c_y_reg[k] <= cy_out[k];
                c_s_reg[k] <= (k == 0) ? b_s_reg : c_s_reg[(k == 0) ? 0 : k-1];
            end
        end
    end

    // ------------------------------------------------------------------------
    // stage d: apply translation gain, truncated toward zero
    // ------------------------------------------------------------------------
    side_t              d_src;
    logic signed [16:0] xe, ye, qxe, qye, gx_sum, gy_sum;
    logic signed [15:0] gx_next, gy_next;

    logic signed [15:0] d_gx_reg, d_gy_reg;
    logic signed [7:0]  d_rt_reg;
    logic               d_act_reg;
    logic [9:0]         d_gm_reg;
    logic               d_auto_reg;

    always_comb
    begin
        d_src  = c_s_reg[NST-1];
        xe     = 17'(d_src.x_val);
        ye     = 17'(d_src.y_val);
        qxe    = $signed({1'b0, c_x_reg[NST-1].work});
        qye    = $signed({1'b0, c_y_reg[NST-1].work});
        gx_sum = d_src.x_val[8] ? xe - qxe : xe + qxe;
        gy_sum = d_src.y_val[8] ? ye - qye : ye + qye;
        // zero centre passes the axis through unboosted
        if (stick_center_reg == 8'd0)
        begin
            gx_sum = xe;
            gy_sum = ye;
        end
        gx_next = gx_sum[15:0];
        gy_next = gy_sum[15:0];
    end

    always_ff @(posedge clk)
    begin
        if (en_d)
        begin
            d_gx_reg   <= gx_next;
            d_gy_reg   <= gy_next;
            d_rt_reg   <= d_src.rt;
            d_act_reg  <= d_src.act;
            d_gm_reg   <= d_src.gm;
            d_auto_reg <= d_src.auto_on;
        end
    end

    // ------------------------------------------------------------------------
    // stage e: mecanum mixing, order FL RL FR RR
    // ------------------------------------------------------------------------
    logic signed [16:0] mx, my, mr;
    logic signed [16:0] mix_next [4];

    logic signed [16:0] e_spd_reg [4];
    logic               e_act_reg;
    logic [9:0]         e_gm_reg;
    logic               e_auto_reg;

    always_comb
    begin
        mx = 17'(d_gx_reg);
        my = 17'(d_gy_reg);
        mr = 17'(d_rt_reg);
        mix_next[0] = -my - mx - mr;
        mix_next[1] = -my + mx - mr;
        mix_next[2] =  my - mx - mr;
        mix_next[3] =  my + mx - mr;
    end

    always_ff @(posedge clk)
    begin
        if (en_e)
        begin
            for (int i = 0; i < 4; i++)
            begin
                e_spd_reg[i] <= mix_next[i];
            end
            e_act_reg  <= d_act_reg;
            e_gm_reg   <= d_gm_reg;
            e_auto_reg <= d_auto_reg;
        end
    end

    // ------------------------------------------------------------------------
    // stage f: scale by gain * (gear + 1)
    // ------------------------------------------------------------------------
    logic signed [27:0] prod_next [4];
    logic signed [27:0] gm_ext;

    logic signed [27:0] f_prod_reg [4];
    logic               f_act_reg;
    logic               f_auto_reg;

    always_comb
    begin
        gm_ext = $signed({18'd0, e_gm_reg});
        for (int i = 0; i < 4; i++)
        begin
            prod_next[i] = 28'(e_spd_reg[i]) * gm_ext;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_f)
        begin
            for (int i = 0; i < 4; i++)
            begin
                f_prod_reg[i] <= prod_next[i];
            end
            f_act_reg  <= e_act_reg;
            f_auto_reg <= e_auto_reg;
        end
    end

    // ------------------------------------------------------------------------
    // output stage: divide by 4 toward zero, saturate, update held speeds
    // ------------------------------------------------------------------------
    logic signed [27:0] adj [4];
    logic signed [27:0] quarter [4];
    logic signed [15:0] sat_next [4];

    logic signed [15:0] spd_reg [4];
    logic               stick_active_reg;
    logic               speeds_updated_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            adj[i]     = f_prod_reg[i] + (f_prod_reg[i][27] ? 28'sd3 : 28'sd0);
            quarter[i] = adj[i] >>> 2;
            if (quarter[i] > 28'sd32767)
                sat_next[i] = 16'sh7FFF;
            else if (quarter[i] < -28'sd32768)
                sat_next[i] = 16'sh8000;
            else
                sat_next[i] = quarter[i][15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                spd_reg[i] <= '0;
            end
            stick_active_reg   <= 1'b0;
            speeds_updated_reg <= 1'b0;
        end
        else if (en_out && f_v_reg)
        begin
            // auto mode keeps the held speeds
            if (!f_auto_reg)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    spd_reg[i] <= sat_next[i];
                end
            end
            stick_active_reg   <= f_act_reg;
            speeds_updated_reg <= !f_auto_reg;
        end
    end

    assign front_left_speed  = spd_reg[0];
    assign rear_left_speed   = spd_reg[1];
    assign front_right_speed = spd_reg[2];
    assign rear_right_speed  = spd_reg[3];
    assign stick_active      = stick_active_reg;
    assign speeds_updated    = speeds_updated_reg;

endmodule

`default_nettype wire

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the mecanum joystick wheel mixer. Joystick words go
// in over valid/ready while an in-bench predictor tracks the held wheel
// speeds and the register settings. Every result word is compared field by
// field. Register settings change between drained phases through the APB port.
// ----------------------------------------------------------------------------

module tb;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_CYCLES   = 300;
    localparam int NUM_SETTINGS  = 8;

    typedef struct packed {
        logic [7:0] strafe;
        logic [7:0] drive;
        logic [7:0] rotate;
        logic [1:0] gear;
        logic       auto_on;
    } joy_word_t;

    typedef struct packed {
        logic signed [15:0] fl;
        logic signed [15:0] rl;
        logic signed [15:0] fr;
        logic signed [15:0] rr;
        logic               active;
        logic               updated;
    } wheel_result_t;

    // mixer prediction: held speeds, register copies and expected results
    class mixer_scoreboard;
        logic [7:0]         center;
        logic [6:0]         band;
        logic signed [15:0] held [4];
        wheel_result_t      expected_q [$];
        int                 n_checked;
        int                 n_errors;

        function new();
            center    = mjwm_pkg::STICK_CENTER_RST;
            band      = mjwm_pkg::DEAD_BAND_RST;
            n_checked = 0;
            n_errors  = 0;
            foreach (held[i])
                held[i] = '0;
        endfunction

        // offset from the edge of the zero zone
        function int axis_offset(input logic [7:0] raw, output bit outside);
            int lo;
            int hi;
            int v;
            lo = int'(center) - int'(band);
            hi = int'(center) + int'(band);
            v  = int'(raw);
            if (v < lo)
            begin
                outside = 1'b1;
                return v - lo;
            end
            if (v < hi)
            begin
                outside = 1'b0;
                return 0;
            end
            outside = 1'b1;
            return v - hi;
        endfunction

        // translation boost, division truncates toward zero
        function int boost(input int v);
            if (center == 8'd0)
                return v;
            return v + (int'(band) * v) / int'(center);
        endfunction

        function logic signed [15:0] scale_sat(input int s, input int mult);
            longint t;
            t = longint'(s) * longint'(mjwm_pkg::WHEEL_GAIN) * longint'(mult) / 4;
            if (t > 32767)
                return 16'sh7FFF;
            if (t < -32768)
                return 16'sh8000;
            return t[15:0];
        endfunction

        function void note_word(input joy_word_t w);
            int            x;
            int            y;
            int            r;
            int            rt;
            int            mult;
            bit            ax;
            bit            ay;
            bit            ar;
            wheel_result_t res;
            x    = boost(axis_offset(w.strafe, ax));
            y    = boost(axis_offset(w.drive, ay));
            r    = axis_offset(w.rotate, ar);
            rt   = r / 3;
            mult = int'(w.gear) + 1;
            if (!w.auto_on)
            begin
                held[0] = scale_sat(-y - x - rt, mult);
                held[1] = scale_sat(-y + x - rt, mult);
                held[2] = scale_sat(y - x - rt, mult);
                held[3] = scale_sat(y + x - rt, mult);
            end
            res.fl      = held[0];
            res.rl      = held[1];
            res.fr      = held[2];
            res.rr      = held[3];
            res.active  = ax | ay;
            res.updated = !w.auto_on;
            expected_q.push_back(res);
        endfunction

        function void check_result(input wheel_result_t got);
            wheel_result_t exp_res;
            if (expected_q.size() == 0)
            begin
                $error("result word with no expectation waiting");
                n_errors++;
                return;
            end
            exp_res = expected_q.pop_front();
            n_checked++;
            if (got.fl !== exp_res.fl)
            begin
                $error("front_left_speed: expected %0d, got %0d", exp_res.fl, got.fl);
                n_errors++;
            end
            if (got.rl !== exp_res.rl)
            begin
                $error("rear_left_speed: expected %0d, got %0d", exp_res.rl, got.rl);
                n_errors++;
            end
            if (got.fr !== exp_res.fr)
            begin
                $error("front_right_speed: expected %0d, got %0d", exp_res.fr, got.fr);
                n_errors++;
            end
            if (got.rr !== exp_res.rr)
            begin
                $error("rear_right_speed: expected %0d, got %0d", exp_res.rr, got.rr);
                n_errors++;
            end
            if (got.active !== exp_res.active)
            begin
                $error("stick_active: expected %0b, got %0b", exp_res.active, got.active);
                n_errors++;
            end
            if (got.updated !== exp_res.updated)
            begin
                $error("speeds_updated: expected %0b, got %0b", exp_res.updated, got.updated);
                n_errors++;
            end
        endfunction

        function int pending_count();
            return expected_q.size();
        endfunction
    endclass

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    logic [7:0]                     strafe_raw = '0;
    logic [7:0]                     drive_raw = '0;
    logic [7:0]                     rotate_raw = '0;
    logic [1:0]                     gear = '0;
    logic                           auto_mode = 1'b0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic signed [15:0]             front_left_speed;
    logic signed [15:0]             rear_left_speed;
    logic signed [15:0]             front_right_speed;
    logic signed [15:0]             rear_right_speed;
    logic                           stick_active;
    logic                           speeds_updated;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [mjwm_pkg::PADDR_W-1:0]   paddr = '0;
    logic [mjwm_pkg::PDATA_W-1:0]   pwdata = '0;
    logic [mjwm_pkg::PDATA_W-1:0]   prdata;
    logic                           pready;

    mixer_scoreboard mixer_sb = new();

    bit gaps_on     = 1'b1;
    bit stalls_on   = 1'b1;
    bit hold_req    = 1'b0;
    int holds_done  = 0;
    int words_sent  = 0;
    int reg_errors  = 0;
    int cycle_count = 0;

    mecanum_joystick_wheel_mixer i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .strafe_raw        (strafe_raw),
        .drive_raw         (drive_raw),
        .rotate_raw        (rotate_raw),
        .gear              (gear),
        .auto_mode         (auto_mode),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .front_left_speed  (front_left_speed),
        .rear_left_speed   (rear_left_speed),
        .front_right_speed (front_right_speed),
        .rear_right_speed  (rear_right_speed),
        .stick_active      (stick_active),
        .speeds_updated    (speeds_updated),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    // clock
    initial
    begin
        forever #2 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // input word monitor feeds the predictor
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            mixer_sb.note_word({strafe_raw, drive_raw, rotate_raw, gear, auto_mode});
    end

    // result word monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            mixer_sb.check_result({front_left_speed, rear_left_speed, front_right_speed,
                                   rear_right_speed, stick_active, speeds_updated});
    end

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                holds_done++;
            end
            else
                out_ready <= !(stalls_on && $urandom_range(0, 99) < 9);
        end
    end

    function automatic logic [7:0] clamp_raw(input int v);
        if (v < 0)
            return 8'd0;
        if (v > 255)
            return 8'd255;
        return v[7:0];
    endfunction

    // uniform byte or one close to a zone edge
    function automatic logic [7:0] random_axis();
        int edge_val;
        if ($urandom_range(0, 1) == 0)
            return 8'($urandom_range(0, 255));
        if ($urandom_range(0, 1) == 0)
            edge_val = int'(mixer_sb.center) - int'(mixer_sb.band);
        else
            edge_val = int'(mixer_sb.center) + int'(mixer_sb.band);
        return clamp_raw(edge_val + int'($urandom_range(0, 4)) - 2);
    endfunction

    function automatic joy_word_t random_word();
        joy_word_t w;
        w.strafe  = random_axis();
        w.drive   = random_axis();
        w.rotate  = random_axis();
        w.gear    = 2'($urandom_range(0, 3));
        w.auto_on = ($urandom_range(0, 99) < 15);
        return w;
    endfunction

    task automatic send_word(input joy_word_t w);
        while (gaps_on && $urandom_range(0, 99) < 9)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        strafe_raw <= w.strafe;
        drive_raw  <= w.drive;
        rotate_raw <= w.rotate;
        gear       <= w.gear;
        auto_mode  <= w.auto_on;
        do
            @(posedge clk);
        while (!in_ready);
        words_sent++;
    endtask

    // sender pauses until every expected result is back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (mixer_sb.pending_count() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic reg_sel, input logic [mjwm_pkg::PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_sel == mjwm_pkg::REG_STICK_CENTER)
            mixer_sb.center = value[7:0];
        else
            mixer_sb.band = value[6:0];
        @(posedge clk);
    endtask

    task automatic apb_read_check(input logic reg_sel);
        logic [mjwm_pkg::PDATA_W-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {reg_sel, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (reg_sel == mjwm_pkg::REG_STICK_CENTER && got[7:0] !== mixer_sb.center)
        begin
            $error("stick_center: expected %0d, got %0d", mixer_sb.center, got[7:0]);
            reg_errors++;
        end
        if (reg_sel == mjwm_pkg::REG_DEAD_BAND && got[6:0] !== mixer_sb.band)
        begin
            $error("dead_band: expected %0d, got %0d", mixer_sb.band, got[6:0]);
            reg_errors++;
        end
        @(posedge clk);
    endtask

    // words that sit on both sides of each zone edge for the current setting
    task automatic send_edge_words();
        int        lo;
        int        hi;
        int        edges [4];
        joy_word_t w;
        lo    = int'(mixer_sb.center) - int'(mixer_sb.band);
        hi    = int'(mixer_sb.center) + int'(mixer_sb.band);
        edges = '{lo - 1, lo, hi - 1, hi};
        foreach (edges[k])
        begin
            w = '{clamp_raw(edges[k]), mixer_sb.center, clamp_raw(edges[k]), k[1:0], 1'b0};
            send_word(w);
            w = '{mixer_sb.center, clamp_raw(edges[k]), 8'($urandom_range(0, 255)),
                  k[1:0], 1'b0};
            send_word(w);
        end
    endtask

    // opening words at reset settings: zone 118..137
    joy_word_t opening_words [18] = '{
        '{8'd128, 8'd128, 8'd128, 2'd0, 1'b0},  // all at rest
        '{8'd117, 8'd128, 8'd128, 2'd1, 1'b0},  // just below the zone
        '{8'd118, 8'd128, 8'd128, 2'd1, 1'b0},  // lowest in the zone
        '{8'd137, 8'd128, 8'd128, 2'd2, 1'b0},  // highest in the zone
        '{8'd138, 8'd128, 8'd128, 2'd2, 1'b0},  // just above the zone
        '{8'd128, 8'd117, 8'd128, 2'd3, 1'b0},
        '{8'd128, 8'd138, 8'd128, 2'd3, 1'b0},
        '{8'd128, 8'd128, 8'd117, 2'd0, 1'b0},  // rotation alone is not stick activity
        '{8'd128, 8'd128, 8'd138, 2'd0, 1'b0},
        '{8'd0,   8'd0,   8'd0,   2'd3, 1'b0},
        '{8'd255, 8'd255, 8'd255, 2'd3, 1'b0},
        '{8'd0,   8'd255, 8'd0,   2'd3, 1'b0},
        '{8'd255, 8'd0,   8'd255, 2'd3, 1'b0},
        '{8'd255, 8'd255, 8'd0,   2'd0, 1'b0},
        '{8'd0,   8'd0,   8'd0,   2'd3, 1'b1},  // auto mode keeps held speeds
        '{8'd128, 8'd128, 8'd128, 2'd1, 1'b1},
        '{8'd128, 8'd255, 8'd128, 2'd0, 1'b0},
        '{8'd255, 8'd128, 8'd255, 2'd1, 1'b1}
    };

    // register settings per phase, extremes first; zero centre included
    int phase_center [NUM_SETTINGS] = '{255, 1, 0, 1, 255, 128, 200, 60};
    int phase_band   [NUM_SETTINGS] = '{127, 0, 127, 127, 0, 10, 33, 90};

    // main sequence
    initial
    begin
        int n_words;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        apb_read_check(mjwm_pkg::REG_STICK_CENTER);
        apb_read_check(mjwm_pkg::REG_DEAD_BAND);
        foreach (opening_words[k])
            send_word(opening_words[k]);
        drain();

        for (int p = 0; p < NUM_SETTINGS; p++)
        begin
            // random upper bits must be dropped by the register
            apb_write(mjwm_pkg::REG_STICK_CENTER,
                      {16'($urandom_range(0, 65535)), 16'h0} |
                      mjwm_pkg::PDATA_W'(phase_center[p]));
            apb_write(mjwm_pkg::REG_DEAD_BAND,
                      {16'($urandom_range(0, 65535)), 16'h0} |
                      mjwm_pkg::PDATA_W'(phase_band[p]) |
                      mjwm_pkg::PDATA_W'($urandom_range(0, 1) << 7));
            apb_read_check(mjwm_pkg::REG_STICK_CENTER);
            apb_read_check(mjwm_pkg::REG_DEAD_BAND);
            send_edge_words();

            gaps_on   = (p != 2);
            stalls_on = (p != 2);
            n_words   = (p == 2) ? 250 : 130;
            for (int k = 0; k < n_words; k++)
            begin
                // long output hold-off while the sender keeps offering words
                if (p == 3 && k == 20)
                begin
                    gaps_on  = 1'b0;
                    hold_req = 1'b1;
                end
                if (p == 3 && k == 80)
                    gaps_on = 1'b1;
                if (p == 5 && k == 65)
                    drain();
                send_word(random_word());
            end
            drain();
        end

        $display("%0d joystick words mixed over %0d register settings, %0d results compared",
                 words_sent, NUM_SETTINGS + 1, mixer_sb.n_checked);
        $display("zone edges, saturation, zero centre, auto hold and %0d output hold-offs seen",
                 holds_done);
        if (mixer_sb.n_errors == 0 && reg_errors == 0 && mixer_sb.pending_count() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[filelist.f]
rtl/mjwm_pkg.sv
rtl/mjwm_div_step.sv
rtl/mecanum_joystick_wheel_mixer.sv
tb/tb.sv
